FILE: rtl/mixed_radix_bin_index_defines.svh
// Assertion macros for the mixed-radix bin index block.
`ifndef MIXED_RADIX_BIN_INDEX_DEFINES_SVH
`define MIXED_RADIX_BIN_INDEX_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define MRBI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define MRBI_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define MRBI_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRBI_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/mrbi_pkg.sv
// Shared constants, codes and types of the mixed-radix bin index block.
`timescale 1ns / 1ps
`default_nettype none

package mrbi_pkg;

	localparam int MAX_AXES   = 6;
	localparam int FLAT_W     = 48;
	localparam int BIN_W      = 8;
	localparam int AXIS_W     = 3;
	localparam int CNT_W      = 3;
	localparam int CNT_MAX    = 7;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STEPS  = FLAT_W / DIV_BITS;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BINS_FIRST = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BINS_LAST  = CFG_IDX_W'(MAX_AXES);

	// Request commands.
	localparam logic CMD_FLATTEN = 1'b0;
	localparam logic CMD_UNPACK  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_COUNT = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_OOB   = STATUS_W'(2);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              flat_step;
		logic              unpack_start;
		logic              div_step;
		logic              div_done;
		logic              out_oob;
		logic              out_digit;
		logic [AXIS_W-1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic [AXIS_W-1:0] used_axes;
		logic              zero_bin;
		logic              quot_nonzero;
		logic              out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mrbi_if.sv
// Channel interfaces: configuration writes, requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface mrbi_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mrbi_pkg::CFG_IDX_W-1:0]   index;
	logic [mrbi_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface mrbi_req_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [mrbi_pkg::BIN_W-1:0]   axis_bin;
	logic                         last_axis;
	logic [mrbi_pkg::FLAT_W-1:0]  flat_in;

	modport source (output valid, output command, output axis_bin, output last_axis,
		output flat_in, input ready);
	modport sink (input valid, input command, input axis_bin, input last_axis,
		input flat_in, output ready);
endinterface

interface mrbi_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mrbi_pkg::FLAT_W-1:0]    flat_out;
	logic [mrbi_pkg::AXIS_W-1:0]    axis_number;
	logic [mrbi_pkg::BIN_W-1:0]     axis_bin_out;
	logic [mrbi_pkg::STATUS_W-1:0]  status;
	logic                           last_result;

	modport source (output valid, output flat_out, output axis_number,
		output axis_bin_out, output status, output last_result, input ready);
	modport sink (input valid, input flat_out, input axis_number,
		input axis_bin_out, input status, input last_result, output ready);
endinterface

`default_nettype wire

FILE: rtl/mrbi_datapath.sv
// Datapath: configuration registers, flatten accumulator, digit divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module mrbi_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mrbi_cfg_if.sink                           cfg,
	input  wire logic [mrbi_pkg::BIN_W-1:0]    axis_bin,
	input  wire logic                          last_axis,
	input  wire logic [mrbi_pkg::FLAT_W-1:0]   flat_in,
	mrbi_rsp_if.source                         rsp,
	input  wire mrbi_pkg::dp_cmd_t             cmd,
	output mrbi_pkg::dp_stat_t                 stat
);

	logic [mrbi_pkg::AXIS_W-1:0]   num_axes_q;
	logic [mrbi_pkg::BIN_W-1:0]    bins_q [mrbi_pkg::MAX_AXES];
	logic [mrbi_pkg::AXIS_W-1:0]   used_axes;
	logic                          zero_bin;
	logic [mrbi_pkg::CFG_IDX_W-1:0] bin_wr_idx;

	logic [mrbi_pkg::FLAT_W-1:0]   acc_q;
	logic [mrbi_pkg::CNT_W-1:0]    cnt_q;
	logic [mrbi_pkg::BIN_W-1:0]    flat_bin;
	logic [mrbi_pkg::FLAT_W+mrbi_pkg::BIN_W-1:0] flat_prod;
	logic [mrbi_pkg::FLAT_W-1:0]   acc_next;
	logic [mrbi_pkg::CNT_W-1:0]    cnt_next;
	logic                          count_bad;

	logic [mrbi_pkg::FLAT_W-1:0]   qr_q;
	logic [mrbi_pkg::BIN_W-1:0]    rem_q;
	logic [mrbi_pkg::BIN_W-1:0]    divisor;
	logic [mrbi_pkg::FLAT_W-1:0]   qr_next;
	logic [mrbi_pkg::BIN_W:0]      rem_next;
	logic [mrbi_pkg::BIN_W-1:0]    digit_q [mrbi_pkg::MAX_AXES];

	logic                          out_valid_q;
	logic [mrbi_pkg::FLAT_W-1:0]   flat_out_q;
	logic [mrbi_pkg::AXIS_W-1:0]   axis_number_q;
	logic [mrbi_pkg::BIN_W-1:0]    axis_bin_out_q;
	logic [mrbi_pkg::STATUS_W-1:0] status_q;
	logic                          last_result_q;
	logic                          flat_load;
	logic                          out_load;

	// Configuration is always accepted.
	assign cfg.ready = 1'b1;
	assign bin_wr_idx = cfg.index - mrbi_pkg::REG_BINS_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_axes_q <= '0;
			for (int k = 0; k < mrbi_pkg::MAX_AXES; k++) begin
				bins_q[k] <= mrbi_pkg::BIN_W'(1);
			end
		end else if (cfg.valid) begin
			if (cfg.index == mrbi_pkg::REG_NUM_AXES) begin
				num_axes_q <= cfg.data[mrbi_pkg::AXIS_W-1:0];
			end else if (cfg.index >= mrbi_pkg::REG_BINS_FIRST &&
				cfg.index <= mrbi_pkg::REG_BINS_LAST) begin
				bins_q[bin_wr_idx] <= cfg.data[mrbi_pkg::BIN_W-1:0];
			end
		end
	end

	always_comb begin
		used_axes = (num_axes_q > mrbi_pkg::AXIS_W'(mrbi_pkg::MAX_AXES)) ?
			mrbi_pkg::AXIS_W'(mrbi_pkg::MAX_AXES) : num_axes_q;
		zero_bin = 1'b0;
		for (int k = 0; k < mrbi_pkg::MAX_AXES; k++) begin
			if (mrbi_pkg::AXIS_W'(k) < used_axes && bins_q[k] == '0) begin
				zero_bin = 1'b1;
			end
		end
	end

	// Horner step of the flatten accumulator; elements past MAX_AXES only count.
	always_comb begin
		flat_bin = (cnt_q < mrbi_pkg::CNT_W'(mrbi_pkg::MAX_AXES)) ? bins_q[cnt_q] : '0;
		flat_prod = {{mrbi_pkg::BIN_W{1'b0}}, acc_q} *
			{{mrbi_pkg::FLAT_W{1'b0}}, flat_bin};
		acc_next = (cnt_q < mrbi_pkg::CNT_W'(mrbi_pkg::MAX_AXES)) ?
			flat_prod[mrbi_pkg::FLAT_W-1:0] +
			{{(mrbi_pkg::FLAT_W-mrbi_pkg::BIN_W){1'b0}}, axis_bin} : acc_q;
		cnt_next = (cnt_q == mrbi_pkg::CNT_W'(mrbi_pkg::CNT_MAX)) ? cnt_q : cnt_q + 1'b1;
		count_bad = (cnt_next != used_axes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.flat_step) begin
			if (last_axis) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_next;
			end
		end
	end

	// Restoring division, DIV_BITS quotient bits per cycle, dividend shifting out of qr_q.
	always_comb begin
		divisor  = bins_q[cmd.axis];
		rem_next = {1'b0, rem_q};
		qr_next  = qr_q;
		for (int i = 0; i < mrbi_pkg::DIV_BITS; i++) begin
			rem_next = {rem_next[mrbi_pkg::BIN_W-1:0], qr_next[mrbi_pkg::FLAT_W-1]};
			qr_next  = {qr_next[mrbi_pkg::FLAT_W-2:0], 1'b0};
			if (rem_next >= {1'b0, divisor}) begin
				rem_next   = rem_next - {1'b0, divisor};
				qr_next[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.unpack_start) begin
			qr_q  <= flat_in;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			qr_q  <= qr_next;
			rem_q <= cmd.div_done ? '0 : rem_next[mrbi_pkg::BIN_W-1:0];
		end
		if (cmd.div_done) begin
			digit_q[cmd.axis] <= rem_next[mrbi_pkg::BIN_W-1:0];
		end
	end

	assign flat_load = cmd.flat_step && last_axis;
	assign out_load  = flat_load || cmd.out_oob || cmd.out_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flat_load) begin
			flat_out_q     <= count_bad ? '0 : acc_next;
			axis_number_q  <= '0;
			axis_bin_out_q <= '0;
			status_q       <= count_bad ? mrbi_pkg::ST_COUNT : mrbi_pkg::ST_OK;
			last_result_q  <= 1'b1;
		end else if (cmd.out_oob) begin
			flat_out_q     <= '0;
			axis_number_q  <= '0;
			axis_bin_out_q <= '0;
			status_q       <= mrbi_pkg::ST_OOB;
			last_result_q  <= 1'b1;
		end else if (cmd.out_digit) begin
			flat_out_q     <= '0;
			axis_number_q  <= cmd.axis;
			axis_bin_out_q <= digit_q[cmd.axis];
			status_q       <= mrbi_pkg::ST_OK;
			last_result_q  <= (cmd.axis == used_axes - 1'b1);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.flat_out     = flat_out_q;
	assign rsp.axis_number  = axis_number_q;
	assign rsp.axis_bin_out = axis_bin_out_q;
	assign rsp.status       = status_q;
	assign rsp.last_result  = last_result_q;

	assign stat.used_axes    = used_axes;
	assign stat.zero_bin     = zero_bin;
	assign stat.quot_nonzero = |qr_q;
	assign stat.out_free     = !out_valid_q || rsp.ready;

endmodule

`default_nettype wire

FILE: rtl/mrbi_ctrl.sv
// Controller: request intake, division sequencing over the axes and result emission.
`timescale 1ns / 1ps
`default_nettype none

module mrbi_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_command,
	output logic                    req_ready,
	input  wire mrbi_pkg::dp_stat_t stat,
	output mrbi_pkg::dp_cmd_t       cmd
);

	mrbi_pkg::state_t              state_q, state_d;
	logic [mrbi_pkg::AXIS_W-1:0]   axis_q, axis_d;
	logic [mrbi_pkg::STEP_W-1:0]   step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrbi_pkg::S_IDLE;
			axis_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		axis_d    = axis_q;
		step_d    = step_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			mrbi_pkg::S_IDLE: begin
				req_ready = stat.out_free;
				if (req_valid && stat.out_free) begin
					if (req_command == mrbi_pkg::CMD_FLATTEN) begin
						cmd.flat_step = 1'b1;
					end else if (stat.used_axes == '0 || stat.zero_bin) begin
						// No axes or a zero bin count: every index is treated as out of range.
						cmd.out_oob = 1'b1;
					end else begin
						cmd.unpack_start = 1'b1;
						axis_d  = stat.used_axes - 1'b1;
						step_d  = '0;
						state_d = mrbi_pkg::S_DIV;
					end
				end
			end
			mrbi_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.axis     = axis_q;
				if (step_q == mrbi_pkg::STEP_W'(mrbi_pkg::DIV_STEPS - 1)) begin
					cmd.div_done = 1'b1;
					step_d = '0;
					if (axis_q == '0) begin
						state_d = mrbi_pkg::S_CHECK;
					end else begin
						axis_d = axis_q - 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			mrbi_pkg::S_CHECK: begin
				// A quotient left after the last axis means the index reached the total.
				if (stat.quot_nonzero) begin
					if (stat.out_free) begin
						cmd.out_oob = 1'b1;
						state_d = mrbi_pkg::S_IDLE;
					end
				end else begin
					axis_d  = '0;
					state_d = mrbi_pkg::S_EMIT;
				end
			end
			mrbi_pkg::S_EMIT: begin
				cmd.axis = axis_q;
				if (stat.out_free) begin
					cmd.out_digit = 1'b1;
					if (axis_q == stat.used_axes - 1'b1) begin
						state_d = mrbi_pkg::S_IDLE;
					end else begin
						axis_d = axis_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = mrbi_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/mixed_radix_bin_index.sv
// Top level of the mixed-radix bin index converter.
//
//   channel  direction  handshake      payload
//   cfg      in         valid/ready    index, data (always ready)
//   req      in         valid/ready    command, axis_bin, last_axis, flat_in
//   rsp      out        valid/ready    flat_out, axis_number, axis_bin_out, status, last_result
//
// A flatten request does one 48x8 multiply-add per element.
// An unpack request runs the shared divider over the axes, highest first, at four quotient
// bits per cycle, then gives one result per cycle while the result register can load.
// Unpack with no axes or a zero bin count answers out of bounds.
// Requests are taken only while the controller is idle and the result register can load.
// Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "mixed_radix_bin_index_defines.svh"

module mixed_radix_bin_index (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mrbi_cfg_if.sink   cfg,
	mrbi_req_if.sink   req,
	mrbi_rsp_if.source rsp
);

	mrbi_pkg::dp_cmd_t  cmd;
	mrbi_pkg::dp_stat_t stat;
	logic               ctrl_ready;

	assign req.ready = ctrl_ready;

	mrbi_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (ctrl_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	mrbi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.axis_bin  (req.axis_bin),
		.last_axis (req.last_axis),
		.flat_in   (req.flat_in),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

	`MRBI_ASSERT(a_no_req_while_div, clk, arst_n, cmd.div_step |-> !req.ready, "request taken during division")
	`MRBI_ASSERT(a_out_load_free, clk, arst_n, (cmd.out_oob || cmd.out_digit) |-> stat.out_free, "result register overwritten")
	`MRBI_ASSERT(a_digit_axis_range, clk, arst_n, cmd.out_digit |-> (cmd.axis < stat.used_axes), "digit emitted beyond axis count")
	`MRBI_ASSERT_NEVER(a_div_zero, clk, arst_n, cmd.div_step && stat.zero_bin, "division by a zero bin count")

endmodule

`default_nettype wire
